@@ rtl/core/sfs_pkg.sv @@
// Shared types and constants for the slot allocator with free stack.
package sfs_pkg;

    // Default sizing
    localparam int SLOTS_DEF     = 256;
    localparam int KIND_BITS_DEF = 8;

    // Fixed field widths of the request and response
    localparam int IDX_FIELD_W  = 8;
    localparam int KIND_FIELD_W = 8;
    localparam int CAP_W        = 9;
    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    // Request codes (code 3 decodes as a lookup)
    localparam logic [1:0] REQ_ALLOC  = 2'd0;
    localparam logic [1:0] REQ_FREE   = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_FREE_IGN = 2'd2;
    localparam logic [1:0] ST_OUT_RNG  = 2'd3;

    typedef struct packed {
        logic [1:0]              req_type;
        logic [IDX_FIELD_W-1:0]  slot_index;
        logic [KIND_FIELD_W-1:0] entity_kind;
    } req_t;

    typedef struct packed {
        logic [IDX_FIELD_W-1:0]  result_index;
        logic [1:0]              status;
        logic [KIND_FIELD_W-1:0] stored_kind;
    } rsp_t;

endpackage

@@ rtl/core/sfs_ram.sv @@
// Single-port-write, single-port-read synchronous RAM with registered read data.
module sfs_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port with registered read data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/slot_allocator_free_stack_top.sv @@
// Top level of the slot allocator: request FSM, free stack and kind store.
//
// Slot index allocator. Index 0 is reserved as "none". Allocate pops the most
// recently freed index, else takes the next fresh index from a high-water
// counter (starting at 1) until it reaches min(capacity, SLOTS); then it
// answers full. Free empties a live slot and pushes it on the stack; lookup
// returns the kind held by an allocated slot. For each request, on acceptance
// the kind store and the top of the free stack are read, and in the execute
// state the synchronous RAMs are updated and the response is registered. A
// new request is taken once the previous one has executed, even while an
// earlier response still waits in the output register; the update stalls
// only if that register is still full. Capacity writes are taken in any cycle.
module slot_allocator_free_stack_top
    import sfs_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int KIND_BITS = KIND_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  req_t             req_data,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output rsp_t             rsp_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_data
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam logic [CMP_W-1:0] SLOTS_C = CMP_W'(SLOTS);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t               state_reg;
    req_t                 req_reg;
    logic [CAP_W-1:0]     cap_reg;
    logic [CNT_W-1:0]     depth_reg;
    logic [CNT_W-1:0]     depth_next;
    logic [CNT_W-1:0]     hw_reg;
    logic [CNT_W-1:0]     hw_next;
    logic                 rsp_valid_reg;
    rsp_t                 rsp_reg;
    rsp_t                 rsp_next;

    logic                 req_fire;
    logic                 exec_fire;

    logic                 kind_we;
    logic [IDX_W-1:0]     kind_waddr;
    logic [KIND_BITS-1:0] kind_wdata;
    logic [KIND_BITS-1:0] kind_rdata;
    logic                 stk_we;
    logic [IDX_W-1:0]     stk_waddr;
    logic [IDX_W-1:0]     stk_wdata;
    logic [IDX_W-1:0]     stk_raddr;
    logic [IDX_W-1:0]     stk_rdata;

    logic [CMP_W-1:0]     idx_c;
    logic [CMP_W-1:0]     hw_c;
    logic                 idx_ok;
    logic [IDX_W-1:0]     idx_mem;

    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign exec_fire = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp_ready);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // Top of stack address for the pop read
    assign stk_raddr = IDX_W'(depth_reg - CNT_W'(1));

    // Range check of the request index against the high-water mark
    assign idx_c   = CMP_W'(req_reg.slot_index);
    assign hw_c    = CMP_W'(hw_reg);
    assign idx_ok  = (idx_c != '0) && (idx_c < hw_c) && (idx_c < SLOTS_C);
    assign idx_mem = IDX_W'(req_reg.slot_index);

    // Execute step: decide the response and the memory updates
    always_comb
    begin
        depth_next            = depth_reg;
        hw_next               = hw_reg;
        kind_we               = 1'b0;
        kind_waddr            = idx_mem;
        kind_wdata            = '0;
        stk_we                = 1'b0;
        stk_waddr             = IDX_W'(depth_reg);
        stk_wdata             = idx_mem;
        rsp_next.result_index = req_reg.slot_index;
        rsp_next.status       = ST_OK;
        rsp_next.stored_kind  = '0;
        case (req_reg.req_type)
            REQ_ALLOC:
            begin
                kind_wdata = KIND_BITS'(req_reg.entity_kind);
                if (depth_reg != '0)
                begin
                    depth_next            = depth_reg - CNT_W'(1);
                    kind_we               = exec_fire;
                    kind_waddr            = stk_rdata;
                    rsp_next.result_index = IDX_FIELD_W'(stk_rdata);
                end
                else if ((hw_c < CMP_W'(cap_reg)) && (hw_c < SLOTS_C))
                begin
                    hw_next               = hw_reg + CNT_W'(1);
                    kind_we               = exec_fire;
                    kind_waddr            = IDX_W'(hw_reg);
                    rsp_next.result_index = IDX_FIELD_W'(hw_reg);
                end
                else
                begin
                    rsp_next.result_index = '0;
                    rsp_next.status       = ST_FULL;
                end
            end
            REQ_FREE:
            begin
                if (!idx_ok || (kind_rdata == '0))
                begin
                    rsp_next.status = ST_FREE_IGN;
                end
                else
                begin
                    kind_we = exec_fire;
                    // push guarded against overflow
                    if (CMP_W'(depth_reg) < SLOTS_C)
                    begin
                        stk_we     = exec_fire;
                        depth_next = depth_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                // lookup
                if (!idx_ok)
                begin
                    rsp_next.status = ST_OUT_RNG;
                end
                else
                begin
                    rsp_next.stored_kind = KIND_FIELD_W'(kind_rdata);
                end
            end
        endcase
    end

    // Control state, counters and response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            req_reg       <= '0;
            cap_reg       <= CAP_RESET;
            depth_reg     <= '0;
            hw_reg        <= CNT_W'(1);
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
            if (exec_fire)
            begin
                rsp_valid_reg <= 1'b1;
                rsp_reg       <= rsp_next;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        req_reg   <= req_data;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (exec_fire)
                    begin
                        depth_reg <= depth_next;
                        hw_reg    <= hw_next;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Kind per slot
    sfs_ram #(
        .DEPTH (SLOTS),
        .WIDTH (KIND_BITS)
    ) u_kind_store (
        .clk   (clk),
        .we    (kind_we),
        .waddr (kind_waddr),
        .wdata (kind_wdata),
        .re    (req_fire),
        .raddr (IDX_W'(req_data.slot_index)),
        .rdata (kind_rdata)
    );

    // LIFO of freed indices
    sfs_ram #(
        .DEPTH (SLOTS),
        .WIDTH (IDX_W)
    ) u_free_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (req_fire),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

endmodule
